// ===== src/hid_report_descriptor_scanner_defines.svh =====
// Assertion helpers shared by the scanner RTL.
`ifndef HID_REPORT_DESCRIPTOR_SCANNER_DEFINES_SVH
`define HID_REPORT_DESCRIPTOR_SCANNER_DEFINES_SVH

// Checked only out of reset.
`define HRDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define HRDS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/hrds_pkg.sv =====
package hrds_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [3:0]  entry_index;
        logic [31:0] report_id;
        logic [31:0] report_count;
        logic        direction;
        logic [4:0]  total_entries;
        logic [4:0]  input_entries;
        logic [4:0]  output_entries;
        logic [2:0]  status;
        logic        final_result;
    } t_out;

    // Queue write strobes: second is only ever set together with first.
    typedef struct packed {
        logic first;
        logic second;
    } t_fifo_wr;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LONG     = 3'd1;
    localparam logic [2:0] ST_RESERVED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic DIR_IN  = 1'b0;
    localparam logic DIR_OUT = 1'b1;

    localparam logic [1:0] TYPE_MAIN     = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL   = 2'd1;
    localparam logic [1:0] TYPE_RESERVED = 2'd3;

    localparam logic [3:0] TAG_INPUT        = 4'd8;
    localparam logic [3:0] TAG_OUTPUT       = 4'd9;
    localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
    localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;
    localparam logic [3:0] TAG_LONG         = 4'd15;

    localparam logic [1:0] SIZE_FOUR = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

endpackage

// ===== src/hrds_result_fifo.sv =====
`include "hid_report_descriptor_scanner_defines.svh"

module hrds_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hrds_pkg::t_fifo_wr i_wr,
    input  hrds_pkg::t_out    i_res0,
    input  hrds_pkg::t_out    i_res1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output hrds_pkg::t_out    o_data
);
    import hrds_pkg::*;

    t_out               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic               pop;
    logic [FIFO_CW-1:0] push_n;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign pop     = o_valid & i_ready;
    assign push_n  = FIFO_CW'(i_wr.first) + FIFO_CW'(i_wr.second);

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(push_n);
        n_rd_ptr = r_rd_ptr + FIFO_AW'(pop);
        n_count  = r_count + push_n - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.first) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_wr.second) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_res1;
        end
    end

    `HRDS_ASSERT(a_count_bound, r_count <= FIFO_CW'(FIFO_DEPTH), "queue overfilled")
    `HRDS_ASSERT(a_second_needs_first, i_wr.second |-> i_wr.first, "second write alone")
    `HRDS_ASSERT(a_write_needs_room, i_wr.first |-> o_room, "write without room")

endmodule

// ===== src/hid_report_descriptor_scanner.sv =====
// HID report descriptor scanner.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one descriptor
// byte per beat, with last_byte set on the final byte of a descriptor.
// Output channel (o_out_valid / i_out_ready / o_out_data) delivers result
// beats: one per Main Input or Main Output item that closes a report entry,
// and one summary beat after the last byte, carrying the entry counts and
// the status of the descriptor. final_result marks the last result caused
// by a byte.
// Results are written into the queue when their byte is accepted. A byte
// is taken every cycle while o_in_ready is high; decode is combinational,
// and results drain through a four-entry queue at one beat a cycle while
// i_out_ready is high. o_in_ready is low while fewer than two queue slots
// are free, so when the receiver stalls the queue fills and input stops
// within a few beats; no result is dropped. A byte that both closes an
// entry and ends the descriptor produces two beats.
// Reset (synchronous, active low) empties the queue and clears the parser
// state; the last byte of every descriptor re-arms the parser the same way.
`include "hid_report_descriptor_scanner_defines.svh"

module hid_report_descriptor_scanner #(
    parameter int MAX_REPORTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hrds_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output hrds_pkg::t_out o_out_data
);
    import hrds_pkg::*;

    localparam int CW = $clog2(MAX_REPORTS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_REPORTS);

    logic [2:0]    r_rem,   n_rem;
    logic [1:0]    r_pos,   n_pos;
    logic [3:0]    r_tag,   n_tag;
    logic [1:0]    r_type,  n_type;
    logic [31:0]   r_acc,   n_acc;
    logic [31:0]   r_id,    n_id;
    logic [31:0]   r_rcnt,  n_rcnt;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [CW-1:0] r_incnt, n_incnt;
    logic [CW-1:0] r_outcnt, n_outcnt;
    logic [2:0]    r_err,   n_err;

    logic          accept;
    logic          fin;
    logic          emit;
    logic          entry_dir;
    logic [7:0]    b;
    logic [CW+4:0] w_idx_x, w_tot_x, w_in_x, w_out_x;
    t_out          entry_res, summary_res, res0;
    t_fifo_wr      fifo_wr;
    logic          fifo_room;

    assign accept = i_in_valid & o_in_ready;
    assign b      = i_in_data.data_byte;

    always_comb begin
        n_rem    = r_rem;
        n_pos    = r_pos;
        n_tag    = r_tag;
        n_type   = r_type;
        n_acc    = r_acc;
        n_id     = r_id;
        n_rcnt   = r_rcnt;
        n_cnt    = r_cnt;
        n_incnt  = r_incnt;
        n_outcnt = r_outcnt;
        n_err    = r_err;
        fin       = 1'b0;
        emit      = 1'b0;
        entry_dir = DIR_IN;
        if (accept && (r_err == ST_OK)) begin
            if (r_rem == 3'd0) begin
                n_tag  = b[7:4];
                n_type = b[3:2];
                n_acc  = '0;
                n_pos  = '0;
                if (b[7:4] == TAG_LONG) begin
                    n_err = ST_LONG;
                end else if (b[3:2] == TYPE_RESERVED) begin
                    n_err = ST_RESERVED;
                end else begin
                    n_rem = (b[1:0] == SIZE_FOUR) ? 3'd4 : {1'b0, b[1:0]};
                    fin   = (b[1:0] == 2'd0);
                end
            end else begin
                n_acc = r_acc | ({24'b0, b} << {r_pos, 3'b000});
                n_pos = r_pos + 2'd1;
                n_rem = r_rem - 3'd1;
                fin   = (r_rem == 3'd1);
            end
        end
        if (fin) begin
            if (r_cnt >= MAX_C) begin
                n_err = ST_FULL;
            end else if (n_type == TYPE_GLOBAL) begin
                if (n_tag == TAG_REPORT_ID) begin
                    n_id = n_acc;
                end else if (n_tag == TAG_REPORT_COUNT) begin
                    n_rcnt = n_acc;
                end
            end else if (n_type == TYPE_MAIN &&
                         (n_tag == TAG_INPUT || n_tag == TAG_OUTPUT)) begin
                emit  = 1'b1;
                n_cnt = r_cnt + CW'(1);
                if (n_tag == TAG_INPUT) begin
                    n_incnt = r_incnt + CW'(1);
                end else begin
                    n_outcnt  = r_outcnt + CW'(1);
                    entry_dir = DIR_OUT;
                end
            end
        end
        // truncation check needs the post-byte state, before re-arm
        if (accept && i_in_data.last_byte && n_err == ST_OK && n_rem != 3'd0) begin
            n_err = ST_TRUNC;
        end
    end

    assign w_idx_x = {5'b0, r_cnt};
    assign w_tot_x = {5'b0, n_cnt};
    assign w_in_x  = {5'b0, n_incnt};
    assign w_out_x = {5'b0, n_outcnt};

    always_comb begin
        entry_res                = '0;
        entry_res.kind           = KIND_ENTRY;
        entry_res.entry_index    = w_idx_x[3:0];
        entry_res.report_id      = r_id;
        entry_res.report_count   = r_rcnt;
        entry_res.direction      = entry_dir;
        entry_res.total_entries  = w_tot_x[4:0];
        entry_res.input_entries  = w_in_x[4:0];
        entry_res.output_entries = w_out_x[4:0];
        entry_res.status         = ST_OK;
        entry_res.final_result   = ~i_in_data.last_byte;

        summary_res                = '0;
        summary_res.kind           = KIND_SUMMARY;
        summary_res.total_entries  = w_tot_x[4:0];
        summary_res.input_entries  = w_in_x[4:0];
        summary_res.output_entries = w_out_x[4:0];
        summary_res.status         = n_err;
        summary_res.final_result   = 1'b1;

        res0           = emit ? entry_res : summary_res;
        fifo_wr.first  = accept & (emit | i_in_data.last_byte);
        fifo_wr.second = accept & emit & i_in_data.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in_data.last_byte)) begin
            r_rem    <= '0;
            r_pos    <= '0;
            r_tag    <= '0;
            r_type   <= '0;
            r_acc    <= '0;
            r_id     <= '0;
            r_rcnt   <= '0;
            r_cnt    <= '0;
            r_incnt  <= '0;
            r_outcnt <= '0;
            r_err    <= ST_OK;
        end else begin
            r_rem    <= n_rem;
            r_pos    <= n_pos;
            r_tag    <= n_tag;
            r_type   <= n_type;
            r_acc    <= n_acc;
            r_id     <= n_id;
            r_rcnt   <= n_rcnt;
            r_cnt    <= n_cnt;
            r_incnt  <= n_incnt;
            r_outcnt <= n_outcnt;
            r_err    <= n_err;
        end
    end

    hrds_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fifo_wr),
        .i_res0  (res0),
        .i_res1  (summary_res),
        .o_room  (fifo_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    assign o_in_ready = fifo_room;

    `HRDS_ASSERT(a_summary_final, (o_out_valid && o_out_data.kind == KIND_SUMMARY) |-> o_out_data.final_result, "summary without final mark")
    `HRDS_ASSERT(a_entry_ok, (o_out_valid && o_out_data.kind == KIND_ENTRY) |-> (o_out_data.status == ST_OK), "entry with error status")
    `HRDS_ASSERT(a_rearm, (accept && i_in_data.last_byte) |=> (r_rem == 3'd0 && r_err == ST_OK && r_cnt == '0), "parser not re-armed after last beat")

endmodule
